// ===== src/htfd_pkg.sv =====
// Shared types, constants and the CRC-8 helper for the humidity/temperature frame decoder.
// No dependencies; every other file of the block imports this package.
package htfd_pkg;

   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h31;

   // frame record queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // scaling constants: temp = floor(17500*raw/65535) - 4500, hum = floor(10000*raw/65535)
   localparam logic [14:0]        TEMP_SPAN   = 15'd17500;
   localparam logic [13:0]        HUM_SPAN    = 14'd10000;
   localparam logic [15:0]        WORD_MAX    = 16'hFFFF;
   localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_CRC_ERR = 1'b1;

   typedef enum logic [2:0] {
      POS_TEMP_HI,
      POS_TEMP_LO,
      POS_TEMP_CRC,
      POS_HUM_HI,
      POS_HUM_LO,
      POS_HUM_CRC
   } pos_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic signed [14:0] temperature_centi;
      logic [13:0]        humidity_centi;
      logic [15:0]        raw_temperature;
      logic [15:0]        raw_humidity;
      logic               status;
   } rsp_type;

   // one complete frame, handed from front to back
   typedef struct packed {
      logic [15:0] raw_temperature;
      logic [15:0] raw_humidity;
      logic        crc_ok;
   } frame_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // CRC-8, MSB first, one byte
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
      end
      return c;
   endfunction

endpackage

// ===== src/htfd_front.sv =====
// Front end: tracks byte position, assembles both words and checks their CRC bytes.
// Depends on htfd_pkg; pushes one frame_type record per complete frame.
module htfd_front import htfd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      accept,
   input  req_type   req,
   output logic      push_valid,
   output frame_type push_frame
);

   pos_type     pos_ff, pos_in;
   logic [7:0]  crc_ff, crc_in;
   logic [15:0] temp_word_ff, temp_word_in;
   logic [15:0] hum_word_ff, hum_word_in;
   logic        first_good_ff, first_good_in;

   pos_type     pos_eff;
   logic [7:0]  crc_eff;
   logic [7:0]  crc_upd;
   logic [7:0]  crc_fresh;

   // frame start restarts position and CRC before the byte is taken
   assign pos_eff   = req.frame_start ? POS_TEMP_HI : pos_ff;
   assign crc_eff   = req.frame_start ? CRC_INIT : crc_ff;
   assign crc_upd   = crc8_byte(crc_eff, req.rx_byte);
   assign crc_fresh = crc8_byte(CRC_INIT, req.rx_byte);

   // next state
   always_comb begin
      pos_in        = pos_ff;
      crc_in        = crc_ff;
      temp_word_in  = temp_word_ff;
      hum_word_in   = hum_word_ff;
      first_good_in = first_good_ff;
      if (accept) begin
         case (pos_eff)
            POS_TEMP_HI: begin
               temp_word_in = {req.rx_byte, temp_word_ff[7:0]};
               crc_in       = crc_upd;
               pos_in       = POS_TEMP_LO;
            end
            POS_TEMP_LO: begin
               temp_word_in = {temp_word_ff[15:8], req.rx_byte};
               crc_in       = crc_upd;
               pos_in       = POS_TEMP_CRC;
            end
            POS_TEMP_CRC: begin
               first_good_in = (crc_eff == req.rx_byte);
               crc_in        = CRC_INIT;
               pos_in        = POS_HUM_HI;
            end
            POS_HUM_HI: begin
               hum_word_in = {req.rx_byte, hum_word_ff[7:0]};
               crc_in      = crc_upd;
               pos_in      = POS_HUM_LO;
            end
            POS_HUM_LO: begin
               hum_word_in = {hum_word_ff[15:8], req.rx_byte};
               crc_in      = crc_upd;
               pos_in      = POS_HUM_CRC;
            end
            POS_HUM_CRC: begin
               crc_in = CRC_INIT;
               pos_in = POS_TEMP_HI;
            end
            default: begin
               // unused code: taken as the first byte of a frame
               temp_word_in = {req.rx_byte, temp_word_ff[7:0]};
               crc_in       = crc_fresh;
               pos_in       = POS_TEMP_LO;
            end
         endcase
      end
   end

   // outputs
   always_comb begin
      push_valid                 = accept && (pos_eff == POS_HUM_CRC);
      push_frame.raw_temperature = temp_word_ff;
      push_frame.raw_humidity    = hum_word_ff;
      push_frame.crc_ok          = first_good_ff && (crc_eff == req.rx_byte);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= POS_TEMP_HI;
         crc_ff        <= CRC_INIT;
         temp_word_ff  <= '0;
         hum_word_ff   <= '0;
         first_good_ff <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         crc_ff        <= crc_in;
         temp_word_ff  <= temp_word_in;
         hum_word_ff   <= hum_word_in;
         first_good_ff <= first_good_in;
      end
   end

endmodule

// ===== src/htfd_queue.sv =====
// Small flop-based FIFO of frame records between the front and the back end.
// Depends on htfd_pkg for frame_type and the queue sizing constants.
module htfd_queue import htfd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  frame_type        push_frame,
   input  logic             pop_ready,
   output logic             pop_valid,
   output frame_type        pop_frame,
   output queue_status_type status
);

   frame_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]       count_ff, count_in;
   logic                      do_push, do_pop;

   localparam logic [QUEUE_AW-1:0] LAST_SLOT = QUEUE_AW'(QUEUE_DEPTH - 1);
   localparam logic [QUEUE_CW-1:0] FULL_CNT  = QUEUE_CW'(QUEUE_DEPTH);

   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);
   assign pop_valid    = !status.empty;
   assign pop_frame    = slot_ff[rd_ptr_ff];
   assign do_push      = push_valid && !status.full;
   assign do_pop       = pop_ready && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_frame;
      end
   end

endmodule

// ===== src/htfd_scale.sv =====
// Back end: scales both raw words (multiply stage, reciprocal-of-65535 stage) into the
// result register. Depends on htfd_pkg for frame_type, rsp_type and the scaling constants.
module htfd_scale import htfd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      frame_valid,
   input  frame_type frame,
   output logic      frame_ready,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp_payload
);

   // stage 1: products
   logic        s1_valid_ff, s1_valid_in;
   logic [30:0] t_prod_ff, t_prod_in;
   logic [29:0] h_prod_ff, h_prod_in;
   logic [15:0] s1_raw_t_ff, s1_raw_h_ff;
   logic        s1_ok_ff;

   // stage 2: result register
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        advance;

   logic [14:0]        t_est, t_q;
   logic [16:0]        t_rem;
   logic signed [15:0] t_diff;
   logic [13:0]        h_est, h_q;
   logic [16:0]        h_rem;

   // the whole pipe moves unless a finished result is held by the receiver
   assign advance     = !rsp_valid_ff || !rsp_stall;
   assign frame_ready = advance;

   assign t_prod_in   = {15'd0, frame.raw_temperature} * {16'd0, TEMP_SPAN};
   assign h_prod_in   = {14'd0, frame.raw_humidity} * {16'd0, HUM_SPAN};
   assign s1_valid_in = advance ? frame_valid : s1_valid_ff;

   // x/65535 = x/65536 + correction; remainder stays below 2*65535
   always_comb begin
      t_est  = t_prod_ff[30:16];
      t_rem  = {1'b0, t_prod_ff[15:0]} + {2'b00, t_est};
      t_q    = (t_rem >= {1'b0, WORD_MAX}) ? t_est + 15'd1 : t_est;
      t_diff = $signed({1'b0, t_q}) - TEMP_OFFSET;

      h_est  = h_prod_ff[29:16];
      h_rem  = {1'b0, h_prod_ff[15:0]} + {3'b000, h_est};
      h_q    = (h_rem >= {1'b0, WORD_MAX}) ? h_est + 14'd1 : h_est;

      rsp_in.raw_temperature = s1_raw_t_ff;
      rsp_in.raw_humidity    = s1_raw_h_ff;
      if (s1_ok_ff) begin
         rsp_in.temperature_centi = t_diff[14:0];
         rsp_in.humidity_centi    = h_q;
         rsp_in.status            = STATUS_OK;
      end else begin
         rsp_in.temperature_centi = '0;
         rsp_in.humidity_centi    = '0;
         rsp_in.status            = STATUS_CRC_ERR;
      end
   end

   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         t_prod_ff   <= t_prod_in;
         h_prod_ff   <= h_prod_in;
         s1_raw_t_ff <= frame.raw_temperature;
         s1_raw_h_ff <= frame.raw_humidity;
         s1_ok_ff    <= frame.crc_ok;
         rsp_ff      <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== src/humidity_temp_frame_decoder.sv =====
// Humidity/temperature sensor frame decoder.
// Channels: req_ (one frame byte per transfer, req_payload.frame_start marks byte one) and
//   rsp_ (one decoded frame per transfer). A transfer happens on a rising edge with valid
//   high and stall low; the receiving side drives stall.
// Frame: temp MSB, temp LSB, temp CRC, hum MSB, hum LSB, hum CRC. CRC-8 poly 0x31,
//   init 0xFF. Only the sixth byte yields a result; frame_start in mid frame drops the
//   partial frame. On a CRC mismatch status is set and both scaled values read zero.
// Throughput: one byte per cycle while req_stall is low. A frame passes the queue, the
//   multiply stage and the result register in that order after its sixth byte is taken.
// Stall: while rsp_stall holds a result, the scaling pipe freezes and completed frames
//   collect in a four-entry queue; req_stall rises only when that queue is full, so bytes
//   that do not complete a frame keep flowing until then.
// Reset (synchronous, active high): byte position to the first byte, CRC to 0xFF, words
//   and the first-CRC flag cleared, queue and pipe emptied, rsp_valid low.
// Depends on htfd_pkg, htfd_front, htfd_queue, htfd_scale.
module humidity_temp_frame_decoder import htfd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic             req_accept;
   logic             push_valid;
   frame_type        push_frame;
   logic             pop_valid;
   logic             pop_ready;
   frame_type        pop_frame;
   queue_status_type q_status;

   // a full queue stalls the byte stream; the front never pushes into a full queue
   assign req_stall  = q_status.full;
   assign req_accept = req_valid && !req_stall;

   // front: position tracking, word assembly, CRC check
   htfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .req        (req_payload),
      .push_valid (push_valid),
      .push_frame (push_frame)
   );

   // decoupling queue of complete frames
   htfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_frame (push_frame),
      .pop_ready  (pop_ready),
      .pop_valid  (pop_valid),
      .pop_frame  (pop_frame),
      .status     (q_status)
   );

   // back: scaling pipe and result register
   htfd_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .frame_valid (pop_valid),
      .frame       (pop_frame),
      .frame_ready (pop_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

`ifndef SYNTHESIS
   // a completed frame is never dropped at the queue
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !q_status.full)
      else $error("frame pushed into full queue");

   // a failed frame carries zeroed scaled values
   a_err_zeroes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == STATUS_CRC_ERR) |->
      (rsp_payload.temperature_centi == '0 && rsp_payload.humidity_centi == '0))
      else $error("CRC error result with nonzero values");

   // scaled humidity stays within 0..100.00 percent
   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.humidity_centi <= 14'd10000))
      else $error("humidity out of range");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");
`endif

endmodule
